/* rtl/ipv4_cidr_pkg.sv */
// shared types and character constants for the ipv4 cidr text parser
`default_nettype none

package ipv4_cidr_pkg;

  localparam int unsigned CH_W     = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PREFIX_W = 6;
  localparam int unsigned NUM_W    = 9;
  localparam int unsigned SUM_W    = 12;

  localparam logic [CH_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CH_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CH_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [CH_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CH_W-1:0] CH_NINE  = 16'h0039;

  localparam logic [SUM_W-1:0]    OCTET_MAX     = 12'd255;
  localparam logic [SUM_W-1:0]    PREFIX_MAX    = 12'd32;
  localparam logic [PREFIX_W-1:0] PREFIX_ABSENT = 6'd32;
  localparam logic [2:0]          OCTETS        = 3'd4;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_OCTET  = 3'd1,
    PH_PREFIX = 3'd3,
    PH_TRAIL  = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

endpackage

`default_nettype wire

/* rtl/ipv4_cidr_text_parser.sv */
// ipv4 dotted text parser with optional /prefix, one 16-bit character per transaction
// a NUL passes through the input register, then sets the result register that drives out_tvalid
// throughput: one character per cycle; input register feeds the parse logic directly
// a NUL stalls in the input register only while the previous result is not yet taken
// reset: synchronous active-low rst_n clears parse state and both valid flags
`default_nettype none

module ipv4_cidr_text_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ipv4_cidr_pkg::CH_W-1:0]    in_tdata,   // ch[15:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [39:0]                            out_tdata,  // address[31:0], prefix_len[37:32]
  output logic                                   out_tuser   // ok[0]
);
  import ipv4_cidr_pkg::*;

  // input register
  logic              in_valid_r;
  logic [CH_W-1:0]   ch_r;

  // parse state
  phase_t              phase_r, phase_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [2:0]          oc_r, oc_nxt;
  logic [NUM_W-1:0]    nv_r, nv_nxt;
  logic                hd_r, hd_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;

  // result register
  logic                out_valid_r;
  logic                out_ok_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [PREFIX_W-1:0] out_prefix_r;

  logic              ch_zero, ch_digit, ch_blank;
  logic [3:0]        digit;
  logic [SUM_W-1:0]  acc10;
  logic              done;
  logic              proc;

  assign ch_zero  = (ch_r == CH_NUL);
  assign ch_digit = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign ch_blank = (ch_r == CH_SPACE) || (ch_r == CH_TAB);
  assign digit    = ch_r[3:0];
  assign acc10    = {nv_r, 3'b000} + {2'b00, nv_r, 1'b0} + {8'd0, digit};

  // a NUL needs a free result slot, any other character always moves on
  assign proc      = in_valid_r && (!ch_zero || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    oc_nxt     = oc_r;
    nv_nxt     = nv_r;
    hd_nxt     = hd_r;
    prefix_nxt = prefix_r;
    done       = 1'b0;

    case (phase_r)
      PH_SKIP: begin
        if (ch_digit) begin
          phase_nxt = PH_OCTET;
          nv_nxt    = {5'd0, digit};
          hd_nxt    = 1'b1;
        end else if (ch_zero) begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_OCTET: begin
        if (ch_digit) begin
          hd_nxt = 1'b1;
          if (acc10 > OCTET_MAX) phase_nxt = PH_ERROR;
          else                   nv_nxt    = acc10[NUM_W-1:0];
        end else if (!hd_r || oc_r >= OCTETS) begin
          phase_nxt = PH_ERROR;
        end else begin
          case (oc_r[1:0])
            2'd0:    addr_nxt[31:24] = nv_r[7:0];
            2'd1:    addr_nxt[23:16] = nv_r[7:0];
            2'd2:    addr_nxt[15:8]  = nv_r[7:0];
            default: addr_nxt[7:0]   = nv_r[7:0];
          endcase
          oc_nxt = oc_r + 3'd1;
          nv_nxt = '0;
          hd_nxt = 1'b0;
          if (oc_nxt == OCTETS) begin
            if (ch_r == CH_SLASH) begin
              phase_nxt = PH_PREFIX;
            end else begin
              // no prefix: same character is checked as trailing text
              prefix_nxt = PREFIX_ABSENT;
              phase_nxt  = PH_TRAIL;
              if (ch_zero)        done      = 1'b1;
              else if (!ch_blank) phase_nxt = PH_ERROR;
            end
          end else if (ch_r != CH_DOT) begin
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_PREFIX: begin
        if (ch_digit) begin
          hd_nxt = 1'b1;
          if (acc10 > PREFIX_MAX) phase_nxt = PH_ERROR;
          else                    nv_nxt    = acc10[NUM_W-1:0];
        end else if (hd_r) begin
          prefix_nxt = nv_r[PREFIX_W-1:0];
          phase_nxt  = PH_TRAIL;
          if (ch_zero)        done      = 1'b1;
          else if (!ch_blank) phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_TRAIL: begin
        if (ch_zero)        done      = 1'b1;
        else if (!ch_blank) phase_nxt = PH_ERROR;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP;
      addr_r   <= '0;
      oc_r     <= '0;
      nv_r     <= '0;
      hd_r     <= 1'b0;
      prefix_r <= '0;
    end else if (proc) begin
      if (ch_zero) begin
        // every string ends with a full restart
        phase_r  <= PH_SKIP;
        addr_r   <= '0;
        oc_r     <= '0;
        nv_r     <= '0;
        hd_r     <= 1'b0;
        prefix_r <= '0;
      end else begin
        phase_r  <= phase_nxt;
        addr_r   <= addr_nxt;
        oc_r     <= oc_nxt;
        nv_r     <= nv_nxt;
        hd_r     <= hd_nxt;
        prefix_r <= prefix_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && ch_zero) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && ch_zero) begin
      out_ok_r     <= done;
      out_addr_r   <= done ? addr_nxt : '0;
      out_prefix_r <= done ? prefix_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {2'b00, out_prefix_r, out_addr_r};

endmodule

`default_nettype wire

/* rtl/ipv4_cidr_chk.sv */
// port-level checker for the ipv4 cidr text parser, bound into the parser module
`default_nettype none

module ipv4_cidr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a failed parse carries an all-zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("failure result with nonzero payload");

  // a good parse never reports a prefix above 32
  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[37:32] <= 6'd32 && out_tdata[39:38] == 2'b00)
    else $error("prefix length out of range");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ipv4_cidr_text_parser ipv4_cidr_chk u_ipv4_cidr_chk (.*);

`default_nettype wire
